// ----- sv/nkbp_pkg.sv -----
// Shared constants and pipeline payload types of the n-gram key bit packer.
`default_nettype none

package nkbp_pkg;

    // Number of word id fields carried by one transaction.
    localparam int ID_FIELDS = 5;
    // Largest n-gram level the block packs.
    localparam int MAX_WORDS = 5;
    // Effective level limit: no more than the id fields, no less than two.
    localparam int WORD_LIMIT = (MAX_WORDS > ID_FIELDS) ? ID_FIELDS :
                                ((MAX_WORDS < 2) ? 2 : MAX_WORDS);
    localparam int MIN_LEVEL  = 2;

    localparam int LVL_W      = 3;
    localparam int ID_W       = 32;
    localparam int LEN_W      = 6;   // significant bit count, 1 to 32
    localparam int HDR_BITS   = 5;   // header bits per word
    localparam int TYPE_W     = HDR_BITS * ID_FIELDS;
    localparam int POS_W      = 8;   // bit position inside the key
    localparam int KEY_WORD_W = 64;
    localparam int KEY_WORDS  = 3;
    localparam int KEY_BITS   = KEY_WORD_W * KEY_WORDS;
    localparam int KLEN_W     = 5;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_DATA_BITS = LVL_W + ID_W * ID_FIELDS;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = KEY_BITS + KLEN_W + TYPE_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    typedef logic [ID_FIELDS-1:0][ID_W-1:0]  t_id_vec;
    typedef logic [ID_FIELDS-1:0][LEN_W-1:0] t_len_vec;
    typedef logic [ID_FIELDS-1:0][POS_W-1:0] t_pos_vec;

    // Registered input transaction.
    typedef struct packed {
        logic [LVL_W-1:0] level;
        t_id_vec          ids;
    } t_s0;

    // After the bit length stage.
    typedef struct packed {
        logic [LVL_W-1:0]     level;
        logic [ID_FIELDS-1:0] used;
        t_id_vec              ids;
        t_len_vec             lens;
    } t_s1;

    // After the offset stage: ids left aligned, each with its key position.
    typedef struct packed {
        logic [TYPE_W-1:0]    type_value;
        logic [TYPE_W-1:0]    hdr_left;
        logic [KLEN_W-1:0]    key_len;
        logic [ID_FIELDS-1:0] used;
        t_id_vec              ids_left;
        t_pos_vec             offsets;
    } t_s2;

    // Finished result.
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [KLEN_W-1:0]   key_len;
        logic [TYPE_W-1:0]   type_value;
    } t_out;

endpackage

`default_nettype wire

// ----- sv/nkbp_len_stage.sv -----
// Pipeline stage that clamps the level and finds each id's significant bit count.
`default_nettype none

module nkbp_len_stage (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  nkbp_pkg::t_s0 i_data,
    output logic          o_valid,
    input  wire           i_ready,
    output nkbp_pkg::t_s1 o_data
);
    import nkbp_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;
    logic [LVL_W-1:0] lvl;

    // Bit count of the highest set bit; zero counts as one bit.
    function automatic logic [LEN_W-1:0] sig_bits(input logic [ID_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = LEN_W'(1);
        for (int b = 1; b < ID_W; b++) begin
            if (v[b]) begin
                n = LEN_W'(b + 1);
            end
        end
        return n;
    endfunction

    // Clamp the level into the supported range.
    always_comb begin
        priority if (i_data.level < LVL_W'(MIN_LEVEL)) begin
            lvl = LVL_W'(MIN_LEVEL);
        end else if (i_data.level > LVL_W'(WORD_LIMIT)) begin
            lvl = LVL_W'(WORD_LIMIT);
        end else begin
            lvl = i_data.level;
        end
    end

    // Per-word bit lengths and the mask of words that take part.
    always_comb begin
        n_data.level = lvl;
        n_data.ids   = i_data.ids;
        for (int i = 0; i < ID_FIELDS; i++) begin
            n_data.used[i] = (LVL_W'(i) < lvl);
            n_data.lens[i] = sig_bits(i_data.ids[i]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- sv/nkbp_ofs_stage.sv -----
// Pipeline stage that builds the type header, key positions and byte length, and left-aligns the ids.
`default_nettype none

module nkbp_ofs_stage (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  nkbp_pkg::t_s1 i_data,
    output logic          o_valid,
    input  wire           i_ready,
    output nkbp_pkg::t_s2 o_data
);
    import nkbp_pkg::*;

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;

    logic [POS_W-1:0]  hdr_bits;
    logic [POS_W-1:0]  total;
    logic [TYPE_W-1:0] type_val;
    t_pos_vec          eff_len;
    t_pos_vec          offs;

    always_comb begin
        hdr_bits = POS_W'(i_data.level) * POS_W'(HDR_BITS);

        // Lengths of the words that take part; the others count as zero.
        type_val = '0;
        for (int i = 0; i < ID_FIELDS; i++) begin
            eff_len[i] = i_data.used[i] ? POS_W'(i_data.lens[i]) : '0;
            if (i_data.used[i]) begin
                type_val[HDR_BITS*i +: HDR_BITS] = HDR_BITS'(i_data.lens[i] - LEN_W'(1));
            end
        end

        // The last word follows the header, earlier words follow later ones.
        offs[ID_FIELDS-1] = hdr_bits;
        for (int i = ID_FIELDS - 2; i >= 0; i--) begin
            offs[i] = offs[i+1] + eff_len[i+1];
        end
        total = offs[0] + eff_len[0];

        n_data.type_value = type_val;
        n_data.hdr_left   = type_val << (TYPE_W - int'(hdr_bits));
        n_data.key_len    = KLEN_W'((total + POS_W'(7)) >> 3);
        n_data.used       = i_data.used;
        n_data.offsets    = offs;
        for (int i = 0; i < ID_FIELDS; i++) begin
            n_data.ids_left[i] = i_data.ids[i] << (LEN_W'(ID_W) - i_data.lens[i]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- sv/nkbp_place_stage.sv -----
// Output stage that shifts the header and the words into place and holds the result.
`default_nettype none

module nkbp_place_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  nkbp_pkg::t_s2  i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output nkbp_pkg::t_out o_data
);
    import nkbp_pkg::*;

    logic r_valid;
    t_out r_data;
    t_out n_data;
    logic [KEY_BITS-1:0] key;

    // Bit 0 of the key is the top bit of the vector; each word is a shifted OR.
    always_comb begin
        key = {i_data.hdr_left, (KEY_BITS - TYPE_W)'(0)};
        for (int i = 0; i < ID_FIELDS; i++) begin
            if (i_data.used[i]) begin
                key = key | ({i_data.ids_left[i], (KEY_BITS - ID_W)'(0)} >> i_data.offsets[i]);
            end
        end
        n_data.key        = key;
        n_data.key_len    = i_data.key_len;
        n_data.type_value = i_data.type_value;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- sv/ngram_key_bit_packer_top.sv -----
// Top level of the n-gram key bit packer: stream ports, input register and pipeline.
`default_nettype none

// Packs an n-gram of 2 to 5 word ids into a variable-length key: a 5-bit-per-word
// header of bit lengths, then the words last to first, each in its significant
// bits, MSB-first from the top of key_word_hi with zero padding. The block is a
// four-register pipeline (input, bit length, offset, placement/output); it takes
// one transaction every cycle while the output is not stalled, and each result
// passes through the input, bit length, offset and placement registers in turn.
// Every stage holds its item while the next one is full, so a stalled output
// backs up at most four transactions before the input stops accepting.
module ngram_key_bit_packer_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // level[2:0], word_id_0[34:3], word_id_1[66:35], word_id_2[98:67],
    // word_id_3[130:99], word_id_4[162:131], zero fill above
    input  wire  [nkbp_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // key_word_hi[63:0], key_word_mid[127:64], key_word_lo[191:128],
    // key_length_bytes[196:192], type_value[221:197], zero fill above
    output logic [nkbp_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);
    import nkbp_pkg::*;

    logic r_s0_valid;
    t_s0  r_s0_data;
    t_s0  n_s0_data;
    logic s1_ready;
    logic s1_valid;
    t_s1  s1_data;
    logic s2_ready;
    logic s2_valid;
    t_s2  s2_data;
    logic out_ready;
    t_out out_data;
    logic s0_ready;
    logic [2:0] r_inflight;

    // Unpack the input transaction.
    always_comb begin
        n_s0_data.level = i_s_axis_tdata[LVL_W-1:0];
        for (int i = 0; i < ID_FIELDS; i++) begin
            n_s0_data.ids[i] = i_s_axis_tdata[LVL_W + ID_W*i +: ID_W];
        end
    end

    // Input register.
    assign s0_ready        = !r_s0_valid || s1_ready;
    assign o_s_axis_tready = s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && i_s_axis_tvalid) begin
            r_s0_data <= n_s0_data;
        end
    end

    nkbp_len_stage u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .o_ready (s1_ready),
        .i_data  (r_s0_data),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_data  (s1_data)
    );

    nkbp_ofs_stage u_ofs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (out_ready),
        .o_data  (s2_data)
    );

    nkbp_place_stage u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (out_ready),
        .i_data  (s2_data),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_data)
    );

    // Pack the result transaction; the key's top 64 bits are key_word_hi.
    assign o_m_axis_tdata = {
        (M_TDATA_W - M_DATA_BITS)'(0),
        out_data.type_value,
        out_data.key_len,
        out_data.key[KEY_WORD_W-1:0],
        out_data.key[2*KEY_WORD_W-1:KEY_WORD_W],
        out_data.key[KEY_BITS-1:2*KEY_WORD_W]
    };

    // Count of transactions accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight
                        + 3'(i_s_axis_tvalid && o_s_axis_tready)
                        - 3'(o_m_axis_tvalid && i_m_axis_tready);
        end
    end

    // Every accepted transaction sits in exactly one pipeline register.
    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 3'($countones({r_s0_valid, s1_valid, s2_valid, o_m_axis_tvalid})))
        else $error("pipeline occupancy does not match transaction count");

    // The key length stays within the header-plus-words range.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_data.key_len >= KLEN_W'(2) &&
                             out_data.key_len <= KLEN_W'(24)))
        else $error("key length out of range");

    // Key bytes past the length are zero in the middle and low words.
    a_pad_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_data.key_len <= KLEN_W'(8)) |->
            out_data.key[2*KEY_WORD_W-1:0] == '0)
        else $error("nonzero key bits past a short key");

    // Key bytes past the length are zero in the low word.
    a_pad_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_data.key_len <= KLEN_W'(16)) |->
            out_data.key[KEY_WORD_W-1:0] == '0)
        else $error("nonzero key bits past a medium key");

endmodule

`default_nettype wire
